FILE: hw/rtl/wheel_encoder_and_hbridge_unit_macros.svh
// Assertion macros shared by the encoder and H-bridge unit RTL.
// Assertions compile away when SYNTH is defined.
`ifndef WHEEL_ENCODER_AND_HBRIDGE_UNIT_MACROS_SVH
`define WHEEL_ENCODER_AND_HBRIDGE_UNIT_MACROS_SVH
`ifndef SYNTH
// Check a property at every rising clock edge outside reset.
`define WEHB_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check that a condition never holds at a rising clock edge outside reset.
`define WEHB_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define WEHB_ASSERT(lbl, clk, rst, prop, msg)
`define WEHB_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

FILE: hw/rtl/wehb_pkg.sv
// Package for the wheel encoder and H-bridge unit: codes, widths, constants
// and the controller/datapath interface structs. No dependencies.
package wehb_pkg;

   localparam int NUM_WHEELS_DEF = 4;

   localparam int WHEEL_W   = 2;
   localparam int TIME_W    = 32;
   localparam int MODE_W    = 2;
   localparam int DUTY_W    = 8;
   localparam int POS_W     = 32;
   localparam int RPM_W     = 16;
   localparam int GEAR_W    = 10;
   localparam int TICKS_W   = 8;
   localparam int CSR_IDX_W = 1;

   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 72;

   // rpm divider: 26-bit dividend, one quotient bit per cycle
   localparam int DIVD_W    = 26;
   localparam int DIV_STEPS = 26;
   localparam int DIV_CNT_W = 5;
   localparam int PROD1_W   = TIME_W + GEAR_W;
   localparam int DEN_W     = PROD1_W + TICKS_W;

   localparam logic [DIVD_W-1:0] US_PER_MIN = 26'd60000000;
   localparam logic [RPM_W-1:0]  RPM_MAX    = 16'hFFFF;
   localparam logic [DUTY_W-1:0] DUTY_FULL  = 8'd255;

   localparam logic signed [POS_W-1:0] POS_TOP    = 32'sd2147483646;
   localparam logic signed [POS_W-1:0] POS_BOTTOM = -32'sd2147483647;

   localparam logic [GEAR_W-1:0]  GEAR_RESET  = 10'd34;
   localparam logic [TICKS_W-1:0] TICKS_RESET = 8'd11;

   localparam logic [CSR_IDX_W-1:0] REG_GEAR  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TICKS = 1'd1;

   typedef enum logic [1:0] {
      CMD_EDGE  = 2'd0,
      CMD_DRIVE = 2'd1,
      CMD_READ  = 2'd2,
      CMD_NONE  = 2'd3
   } wehb_cmd_type;

   typedef enum logic [1:0] {
      MODE_STOP  = 2'd0,
      MODE_FWD   = 2'd1,
      MODE_REV   = 2'd2,
      MODE_BRAKE = 2'd3
   } wehb_mode_type;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_EXEC = 6'b000010,
      ST_MUL1 = 6'b000100,
      ST_MUL2 = 6'b001000,
      ST_DIV  = 6'b010000,
      ST_DONE = 6'b100000
   } wehb_state_type;

   typedef struct packed {
      logic load;
      logic exec;
      logic mul1;
      logic mul2;
      logic div_step;
      logic out_load;
   } wehb_ctl_type;

   typedef struct packed {
      logic is_read;
      logic div_last;
   } wehb_stat_type;

endpackage

FILE: hw/rtl/wehb_datapath.sv
// Datapath of the encoder and H-bridge unit: wheel state, config registers,
// rpm multiply and serial divide, result register. Uses wehb_pkg.
module wehb_datapath import wehb_pkg::*; #(
   parameter int NUM_WHEELS = NUM_WHEELS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   input  logic [1:0]             req_tuser,
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [GEAR_W-1:0]      csr_wdata,
   input  wehb_ctl_type           ctl,
   output wehb_stat_type          stat,
   output logic [RSP_DATA_W-1:0]  rsp_tdata
);

   localparam int IDX_W = (NUM_WHEELS > 1) ? $clog2(NUM_WHEELS) : 1;
   localparam logic [4:0] WHEEL_LIM = 5'(NUM_WHEELS);

   // latched request
   logic [1:0]         cmd_ff, cmd_in;
   logic [WHEEL_W-1:0] wheel_ff, wheel_in;
   logic [TIME_W-1:0]  time_ff, time_in;
   logic [MODE_W-1:0]  mode_ff, mode_in;
   logic [DUTY_W-1:0]  duty_ff, duty_in;

   // configuration
   logic [GEAR_W-1:0]  gear_ff, gear_in;
   logic [TICKS_W-1:0] ticks_ff, ticks_in;

   // per-wheel state
   logic [TIME_W-1:0]        last_time_ff [NUM_WHEELS];
   logic [TIME_W-1:0]        last_time_in [NUM_WHEELS];
   logic [TIME_W-1:0]        period_ff    [NUM_WHEELS];
   logic [TIME_W-1:0]        period_in    [NUM_WHEELS];
   logic signed [POS_W-1:0]  pos_ff       [NUM_WHEELS];
   logic signed [POS_W-1:0]  pos_in       [NUM_WHEELS];
   logic [MODE_W-1:0]        drive_ff     [NUM_WHEELS];
   logic [MODE_W-1:0]        drive_in     [NUM_WHEELS];
   logic [DUTY_W-1:0]        hold_ff      [NUM_WHEELS];
   logic [DUTY_W-1:0]        hold_in      [NUM_WHEELS];

   // result fields and rpm path
   logic [DUTY_W-1:0]  res_a_ff, res_a_in;
   logic [DUTY_W-1:0]  res_b_ff, res_b_in;
   logic [POS_W-1:0]   res_pos_ff, res_pos_in;
   logic [MODE_W-1:0]  res_dir_ff, res_dir_in;
   logic               rd_flag_ff, rd_flag_in;
   logic [TIME_W-1:0]  op_period_ff, op_period_in;
   logic [PROD1_W-1:0] prod1_ff, prod1_in;
   logic [DEN_W-1:0]   den_ff, den_in;
   logic [DIVD_W-1:0]  rem_ff, rem_in;
   logic [DIVD_W-1:0]  quo_ff, quo_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [RSP_DATA_W-1:0] out_ff, out_in;

   logic [IDX_W-1:0]        idx;
   logic                    wheel_ok;
   logic [TIME_W-1:0]       cur_last;
   logic [TIME_W-1:0]       cur_period;
   logic signed [POS_W-1:0] cur_pos;
   logic [MODE_W-1:0]       cur_mode;
   logic [DUTY_W-1:0]       cur_duty;
   logic                    advance;
   logic signed [POS_W-1:0] step_pos;
   logic signed [POS_W-1:0] post_pos;
   logic [MODE_W-1:0]       post_mode;
   logic [DUTY_W-1:0]       post_duty;
   logic [DIVD_W:0]         shifted;
   logic [DEN_W-1:0]        diff;
   logic                    fits;
   logic [RPM_W-1:0]        rpm_val;

   assign idx      = IDX_W'(wheel_ff);
   assign wheel_ok = {3'b000, wheel_ff} < WHEEL_LIM;

   assign cur_last   = last_time_ff[idx];
   assign cur_period = period_ff[idx];
   assign cur_pos    = pos_ff[idx];
   assign cur_mode   = drive_ff[idx];
   assign cur_duty   = hold_ff[idx];

   assign stat.is_read  = wheel_ok && (cmd_ff == CMD_READ);
   assign stat.div_last = cnt_ff == DIV_CNT_W'(DIV_STEPS - 1);

   // edge: time must have risen to count
   always_comb begin
      advance  = cur_last < time_ff;
      step_pos = cur_pos;
      if (advance) begin
         case (cur_mode)
            MODE_FWD:   step_pos = (cur_pos >= POS_TOP) ? '0 : cur_pos + 32'sd1;
            MODE_REV:   step_pos = (cur_pos <= POS_BOTTOM) ? '0 : cur_pos - 32'sd1;
            default:    step_pos = cur_pos;
         endcase
      end
      post_pos  = (cmd_ff == CMD_EDGE)  ? step_pos : cur_pos;
      post_mode = (cmd_ff == CMD_DRIVE) ? mode_ff : cur_mode;
      post_duty = (cmd_ff == CMD_DRIVE) ? duty_ff : cur_duty;
   end

   // one restoring divide step
   assign shifted = {rem_ff, quo_ff[DIVD_W-1]};
   assign diff    = {{(DEN_W-DIVD_W-1){1'b0}}, shifted} - den_ff;
   assign fits    = {{(DEN_W-DIVD_W-1){1'b0}}, shifted} >= den_ff;
   assign rpm_val = (den_ff == '0) ? '0 :
                    (|quo_ff[DIVD_W-1:RPM_W]) ? RPM_MAX : quo_ff[RPM_W-1:0];

   always_comb begin
      cmd_in       = cmd_ff;
      wheel_in     = wheel_ff;
      time_in      = time_ff;
      mode_in      = mode_ff;
      duty_in      = duty_ff;
      gear_in      = gear_ff;
      ticks_in     = ticks_ff;
      last_time_in = last_time_ff;
      period_in    = period_ff;
      pos_in       = pos_ff;
      drive_in     = drive_ff;
      hold_in      = hold_ff;
      res_a_in     = res_a_ff;
      res_b_in     = res_b_ff;
      res_pos_in   = res_pos_ff;
      res_dir_in   = res_dir_ff;
      rd_flag_in   = rd_flag_ff;
      op_period_in = op_period_ff;
      prod1_in     = prod1_ff;
      den_in       = den_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      out_in       = out_ff;

      if (csr_we) begin
         case (csr_index)
            REG_GEAR:  gear_in  = csr_wdata;
            REG_TICKS: ticks_in = csr_wdata[TICKS_W-1:0];
            default:   gear_in  = gear_ff;
         endcase
      end

      if (ctl.load) begin
         cmd_in   = req_tuser;
         wheel_in = req_tdata[1:0];
         time_in  = req_tdata[33:2];
         mode_in  = req_tdata[35:34];
         duty_in  = req_tdata[43:36];
      end

      if (ctl.exec) begin
         rd_flag_in = stat.is_read;
         if (wheel_ok) begin
            case (cmd_ff)
               CMD_EDGE: begin
                  last_time_in[idx] = time_ff;
                  pos_in[idx]       = step_pos;
                  if (advance) begin
                     period_in[idx] = time_ff - cur_last;
                  end
               end
               CMD_DRIVE: begin
                  drive_in[idx] = mode_ff;
                  hold_in[idx]  = duty_ff;
               end
               CMD_READ: begin
                  op_period_in   = cur_period;
                  period_in[idx] = '0;
               end
               default: op_period_in = op_period_ff;
            endcase
            res_pos_in = post_pos;
            res_dir_in = post_mode;
            case (post_mode)
               MODE_FWD:   begin res_a_in = post_duty; res_b_in = '0;        end
               MODE_REV:   begin res_a_in = '0;        res_b_in = post_duty; end
               MODE_BRAKE: begin res_a_in = DUTY_FULL; res_b_in = DUTY_FULL; end
               default:    begin res_a_in = '0;        res_b_in = '0;        end
            endcase
         end else begin
            res_a_in   = '0;
            res_b_in   = '0;
            res_pos_in = '0;
            res_dir_in = '0;
         end
      end

      if (ctl.mul1) begin
         prod1_in = PROD1_W'(op_period_ff) * PROD1_W'(gear_ff);
      end

      if (ctl.mul2) begin
         den_in = DEN_W'(prod1_ff) * DEN_W'(ticks_ff);
         rem_in = '0;
         quo_in = US_PER_MIN;
         cnt_in = '0;
      end

      if (ctl.div_step) begin
         rem_in = fits ? diff[DIVD_W-1:0] : shifted[DIVD_W-1:0];
         quo_in = {quo_ff[DIVD_W-2:0], fits};
         cnt_in = cnt_ff + DIV_CNT_W'(1);
      end

      if (ctl.out_load) begin
         out_in = {6'b0, res_dir_ff, (rd_flag_ff ? rpm_val : RPM_W'(0)),
                   res_pos_ff, res_b_ff, res_a_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gear_ff      <= GEAR_RESET;
         ticks_ff     <= TICKS_RESET;
         cnt_ff       <= '0;
         rd_flag_ff   <= 1'b0;
         for (int i = 0; i < NUM_WHEELS; i++) begin
            last_time_ff[i] <= '0;
            period_ff[i]    <= '0;
            pos_ff[i]       <= '0;
            drive_ff[i]     <= MODE_STOP;
            hold_ff[i]      <= '0;
         end
      end else begin
         gear_ff      <= gear_in;
         ticks_ff     <= ticks_in;
         cnt_ff       <= cnt_in;
         rd_flag_ff   <= rd_flag_in;
         last_time_ff <= last_time_in;
         period_ff    <= period_in;
         pos_ff       <= pos_in;
         drive_ff     <= drive_in;
         hold_ff      <= hold_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      wheel_ff     <= wheel_in;
      time_ff      <= time_in;
      mode_ff      <= mode_in;
      duty_ff      <= duty_in;
      res_a_ff     <= res_a_in;
      res_b_ff     <= res_b_in;
      res_pos_ff   <= res_pos_in;
      res_dir_ff   <= res_dir_in;
      op_period_ff <= op_period_in;
      prod1_ff     <= prod1_in;
      den_ff       <= den_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      out_ff       <= out_in;
   end

   assign rsp_tdata = out_ff;

endmodule

FILE: hw/rtl/wehb_controller.sv
// Controller state machine of the encoder and H-bridge unit: sequences
// update, multiply, divide and result handoff. Uses wehb_pkg and the macros.
`include "wheel_encoder_and_hbridge_unit_macros.svh"
module wehb_controller import wehb_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   input  wehb_stat_type stat,
   output wehb_ctl_type  ctl
);

   wehb_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           accept;
   logic           slot_free;

   assign req_tready = state_ff == ST_IDLE;
   assign accept     = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   assign ctl.load     = accept;
   assign ctl.exec     = state_ff == ST_EXEC;
   assign ctl.mul1     = state_ff == ST_MUL1;
   assign ctl.mul2     = state_ff == ST_MUL2;
   assign ctl.div_step = state_ff == ST_DIV;
   assign ctl.out_load = (state_ff == ST_DONE) && slot_free;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (accept) state_in = ST_EXEC;
         ST_EXEC: state_in = stat.is_read ? ST_MUL1 : ST_DONE;
         ST_MUL1: state_in = ST_MUL2;
         ST_MUL2: state_in = ST_DIV;
         ST_DIV:  if (stat.div_last) state_in = ST_DONE;
         ST_DONE: if (slot_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // hold the result until the sink takes it
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctl.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   `WEHB_ASSERT(a_accept_exec, clock, reset, accept |=> (state_ff == ST_EXEC), "accept not followed by update")
   `WEHB_ASSERT(a_div_done, clock, reset, ((state_ff == ST_DIV) && stat.div_last) |=> (state_ff == ST_DONE), "divide did not finish")
   `WEHB_ASSERT(a_rsp_from_done, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE), "result raised outside handoff")

endmodule

FILE: hw/rtl/wheel_encoder_and_hbridge_unit.sv
// Sequence: edge, drive, unused and invalid-wheel items pass update and handoff; a read
// of a valid wheel passes update, two multiply stages, a 26-step serial divide, handoff.
// The rpm divider forms one quotient bit per cycle. A new item is taken only in idle,
// after the last one is handed off; it may be taken while that result waits for the sink.
// Reset is synchronous, active high: clears all wheel state, sets gear_ratio 34, ticks 11.
module wheel_encoder_and_hbridge_unit import wehb_pkg::*; #(
   parameter int NUM_WHEELS = NUM_WHEELS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // wheel[1:0], time_us[33:2], drive_mode[35:34], duty[43:36], zero[47:44]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // cmd[1:0]
   input  logic [1:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // pwm_a[7:0], pwm_b[15:8], position[47:16], rpm[63:48], direction[65:64], zero[71:66]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [GEAR_W-1:0]     csr_wdata
);

   wehb_ctl_type  ctl;
   wehb_stat_type stat;

   wehb_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .ctl        (ctl)
   );

   wehb_datapath #(
      .NUM_WHEELS (NUM_WHEELS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .ctl       (ctl),
      .stat      (stat),
      .rsp_tdata (rsp_tdata)
   );

endmodule
